FILE: hdl/evgc_pkg.sv
package evgc_pkg;

	// Size of the watched-event table and of its configuration space
	localparam int unsigned REG_SLOTS   = 8;
	localparam int unsigned ENTRIES_DEF = 8;
	localparam int unsigned IDX_W       = 3;
	localparam int unsigned ID_W        = 12;
	localparam int unsigned CFG_W       = 27;
	localparam int unsigned CLASSES     = 4;

	typedef enum logic [1:0] {
		CLS_OK_EVERY    = 2'd0,
		CLS_OK_SOME     = 2'd1,
		CLS_FAULT_SOME  = 2'd2,
		CLS_FAULT_EVERY = 2'd3
	} class_t;

	typedef enum logic [2:0] {
		VERDICT_NONE        = 3'd0,
		VERDICT_FAULT_EVERY = 3'd1,
		VERDICT_FAULT_SOME  = 3'd2,
		VERDICT_OK_EVERY    = 3'd3,
		VERDICT_OK_SOME     = 3'd4
	} verdict_t;

	typedef enum logic {
		FUNC_REPORT = 1'b0,
		FUNC_CLEAR  = 1'b1
	} func_t;

	// Register layout: enable at bit 26, class at 25:24, event id 23:12, module id 11:0
	typedef struct packed {
		logic              enable;
		class_t            cls;
		logic [ID_W-1:0]   evt;
		logic [ID_W-1:0]   mod;
	} entry_t;

	// Per-group reduction results
	typedef struct packed {
		logic [CLASSES-1:0] present;
		logic [CLASSES-1:0] all_ok;
		logic [CLASSES-1:0] any_ok;
	} group_t;

endpackage

FILE: hdl/evgc_match.sv
module evgc_match #(
	parameter int unsigned ENTRIES = evgc_pkg::ENTRIES_DEF
) (
	input  evgc_pkg::entry_t [ENTRIES-1:0] entries,
	input  logic [ENTRIES-1:0]             seen,
	input  logic [evgc_pkg::ID_W-1:0]      source_module,
	input  logic [evgc_pkg::ID_W-1:0]      event_code,
	output logic [ENTRIES-1:0]             seen_next
);

	// Set the sticky flag of every enabled entry that names this event
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			seen_next[i] = seen[i] | (entries[i].enable &&
				entries[i].mod == source_module && entries[i].evt == event_code);
		end
	end

endmodule

FILE: hdl/evgc_reduce.sv
module evgc_reduce #(
	parameter int unsigned ENTRIES = evgc_pkg::ENTRIES_DEF
) (
	input  evgc_pkg::entry_t [ENTRIES-1:0] entries,
	input  logic [ENTRIES-1:0]             seen,
	output evgc_pkg::verdict_t             verdict
);

	evgc_pkg::group_t grp;

	always_comb begin
		grp.present = '0;
		grp.all_ok  = '1;
		grp.any_ok  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			for (int c = 0; c < evgc_pkg::CLASSES; c++) begin
				if (entries[i].enable && entries[i].cls == evgc_pkg::class_t'(c)) begin
					grp.present[c] = 1'b1;
					grp.all_ok[c]  = grp.all_ok[c] & seen[i];
					grp.any_ok[c]  = grp.any_ok[c] | seen[i];
				end
			end
		end
	end

	// Pick the first group that holds, errors before valids
	always_comb begin
		if (grp.present[evgc_pkg::CLS_FAULT_EVERY] &&
				grp.all_ok[evgc_pkg::CLS_FAULT_EVERY]) begin
			verdict = evgc_pkg::VERDICT_FAULT_EVERY;
		end else if (grp.present[evgc_pkg::CLS_FAULT_SOME] &&
				grp.any_ok[evgc_pkg::CLS_FAULT_SOME]) begin
			verdict = evgc_pkg::VERDICT_FAULT_SOME;
		end else if (grp.present[evgc_pkg::CLS_OK_EVERY] &&
				grp.all_ok[evgc_pkg::CLS_OK_EVERY]) begin
			verdict = evgc_pkg::VERDICT_OK_EVERY;
		end else if (grp.present[evgc_pkg::CLS_OK_SOME] &&
				grp.any_ok[evgc_pkg::CLS_OK_SOME]) begin
			verdict = evgc_pkg::VERDICT_OK_SOME;
		end else begin
			verdict = evgc_pkg::VERDICT_NONE;
		end
	end

endmodule

FILE: hdl/event_group_combiner_core.sv
// A report request's verdict passes through the input register, then the result register,
// and is held on the result port until it is taken. Clear requests give no result and
// finish in the input register. Throughput: one request per cycle while the result channel
// does not stall; the result register frees itself while its verdict is taken.
// Reset (arst_n low, asynchronous): all entries disabled, all seen flags cleared, both
// pipeline stages emptied.
module event_group_combiner_core #(
	parameter int unsigned ENTRIES = evgc_pkg::ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,

	// Configuration write port
	input  logic                          cfg_wr_en,
	input  logic [evgc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [evgc_pkg::CFG_W-1:0]    cfg_data,

	// Request channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [evgc_pkg::ID_W-1:0]     source_module,
	input  logic [evgc_pkg::ID_W-1:0]     event_code,

	// Result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    verdict
);

	// Watched-event table and sticky seen flags; only the first ENTRIES slots exist,
	// writes to the slots beyond them are dropped since they never take part.
	evgc_pkg::entry_t [ENTRIES-1:0] entry_q;
	logic [ENTRIES-1:0]             seen_q;

	// Stage 1: registered request
	logic                           valid_s1;
	logic                           func_s1;
	logic [evgc_pkg::ID_W-1:0]      mod_s1;
	logic [evgc_pkg::ID_W-1:0]      evt_s1;

	// Stage 2: result register
	logic                           valid_s2;
	evgc_pkg::verdict_t             verdict_s2;

	logic                           out_free;
	logic                           adv_s1;
	logic [ENTRIES-1:0]             seen_next;
	evgc_pkg::verdict_t             verdict_next;

	// The result register is free when empty or when its verdict is being taken.
	// A clear request leaves stage 1 regardless, since it produces no result.
	assign out_free = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && (func_s1 == evgc_pkg::FUNC_CLEAR || out_free);
	assign in_ready = !valid_s1 || adv_s1;

	// Match the stage-1 event against the table and fold it into the flags
	evgc_match #(
		.ENTRIES       (ENTRIES)
	) u_match (
		.entries       (entry_q),
		.seen          (seen_q),
		.source_module (mod_s1),
		.event_code    (evt_s1),
		.seen_next     (seen_next)
	);

	// Reduce the updated flags per group and pick the verdict
	evgc_reduce #(
		.ENTRIES (ENTRIES)
	) u_reduce (
		.entries (entry_q),
		.seen    (seen_next),
		.verdict (verdict_next)
	);

	// Table registers: a write also clears the seen flag of that entry. Configuration is to
	// arrive only while the pipeline is empty, so no request races it; it is not enforced here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			seen_q  <= '0;
		end else begin
			if (adv_s1) begin
				if (func_s1 == evgc_pkg::FUNC_CLEAR) begin
					seen_q <= '0;
				end else begin
					seen_q <= seen_next;
				end
			end
			for (int i = 0; i < ENTRIES; i++) begin
				if (cfg_wr_en && cfg_index == evgc_pkg::IDX_W'(i)) begin
					entry_q[i] <= evgc_pkg::entry_t'(cfg_data);
					seen_q[i]  <= 1'b0;
				end
			end
		end
	end

	// Stage 1 control: load on acceptance, drop once advanced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage 1 payload: hold while stalled
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1 <= func;
			mod_s1  <= source_module;
			evt_s1  <= event_code;
		end
	end

	// Stage 2 control: only report requests produce a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= adv_s1 && func_s1 == evgc_pkg::FUNC_REPORT;
		end
	end

	// Stage 2 payload: advance the verdict only with a report request
	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && func_s1 == evgc_pkg::FUNC_REPORT) begin
			verdict_s2 <= verdict_next;
		end
	end

	assign out_valid = valid_s2;
	assign verdict   = verdict_s2;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

// Self-checking bench for event_group_combiner_core.
// Requests come from a queue that the stimulus block fills phase by phase. The table is
// rewritten only while the block is drained. Accepted report requests are run through a
// local predictor of the seen flags and the group reduction. Every verdict taken from
// the result channel is compared with the oldest prediction.
module tb;

	typedef struct {
		evgc_pkg::func_t           fn;
		logic [evgc_pkg::ID_W-1:0] mod;
		logic [evgc_pkg::ID_W-1:0] evt;
	} event_req_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_wr_en = 1'b0;
	logic [evgc_pkg::IDX_W-1:0]   cfg_index = '0;
	logic [evgc_pkg::CFG_W-1:0]   cfg_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic                         func = evgc_pkg::FUNC_REPORT;
	logic [evgc_pkg::ID_W-1:0]    source_module = '0;
	logic [evgc_pkg::ID_W-1:0]    event_code = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [2:0]                   verdict;

	// Predictor state: table as the block holds it, plus one sticky flag per entry
	evgc_pkg::entry_t             watch [evgc_pkg::REG_SLOTS] = '{default: '0};
	logic [evgc_pkg::REG_SLOTS-1:0] seen = '0;
	evgc_pkg::verdict_t           verdict_q [$];

	// Table image kept by the stimulus side, used to aim events at watched entries
	evgc_pkg::entry_t             tbl_img [evgc_pkg::REG_SLOTS] = '{default: '0};
	event_req_t                   pend_q [$];

	bit                  req_taken = 1'b0;
	int                  tx_gap = 0;
	bit                  tx_dense = 1'b0;
	bit                  tx_no_gap = 1'b0;
	int                  rx_gap = 0;
	bit                  rx_dense = 1'b0;
	int                  rx_hold_len = 0;

	int                  mismatches = 0;
	int                  n_reports = 0;
	int                  n_clears = 0;
	int                  n_checked = 0;
	int                  verdict_hits [5] = '{default: 0};

	event_group_combiner_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.source_module (source_module),
		.event_code    (event_code),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.verdict       (verdict)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, some medium, a few long; none at all in a dense stretch
	function automatic int gap_len(bit dense);
		int r;
		r = $urandom_range(0, 99);
		if (dense || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Mark matching enabled entries as seen, then reduce per class and rank the groups
	function automatic evgc_pkg::verdict_t predict_verdict(logic [evgc_pkg::ID_W-1:0] mod,
		logic [evgc_pkg::ID_W-1:0] evt);
		logic [evgc_pkg::CLASSES-1:0] present;
		logic [evgc_pkg::CLASSES-1:0] all_ok;
		logic [evgc_pkg::CLASSES-1:0] any_ok;
		present = '0;
		all_ok = '1;
		any_ok = '0;
		for (int i = 0; i < evgc_pkg::ENTRIES_DEF; i++) begin
			if (watch[i].enable) begin
				if (watch[i].mod == mod && watch[i].evt == evt)
					seen[i] = 1'b1;
				present[watch[i].cls] = 1'b1;
				all_ok[watch[i].cls] = all_ok[watch[i].cls] & seen[i];
				any_ok[watch[i].cls] = any_ok[watch[i].cls] | seen[i];
			end
		end
		if (present[evgc_pkg::CLS_FAULT_EVERY] && all_ok[evgc_pkg::CLS_FAULT_EVERY])
			return evgc_pkg::VERDICT_FAULT_EVERY;
		if (present[evgc_pkg::CLS_FAULT_SOME] && any_ok[evgc_pkg::CLS_FAULT_SOME])
			return evgc_pkg::VERDICT_FAULT_SOME;
		if (present[evgc_pkg::CLS_OK_EVERY] && all_ok[evgc_pkg::CLS_OK_EVERY])
			return evgc_pkg::VERDICT_OK_EVERY;
		if (present[evgc_pkg::CLS_OK_SOME] && any_ok[evgc_pkg::CLS_OK_SOME])
			return evgc_pkg::VERDICT_OK_SOME;
		return evgc_pkg::VERDICT_NONE;
	endfunction

	// Monitor: check the result first, then apply table writes and the accepted request.
	// A result leaving at this edge always belongs to an earlier request.
	always @(posedge clk) begin
		evgc_pkg::verdict_t want;
		if (!arst_n) begin
			req_taken = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					mismatches++;
					$display("%0t: verdict %0d with no request outstanding", $time, verdict);
				end else begin
					want = verdict_q.pop_front();
					n_checked++;
					verdict_hits[want]++;
					if (verdict !== want) begin
						mismatches++;
						$display("%0t: verdict mismatch, expected %0d (%s), got %0d",
							$time, want, want.name(), verdict);
					end
				end
			end
			// A table write also drops the seen flag of that entry
			if (cfg_wr_en) begin
				watch[cfg_index] = evgc_pkg::entry_t'(cfg_data);
				seen[cfg_index] = 1'b0;
			end
			req_taken = in_valid && in_ready;
			if (req_taken) begin
				if (func == evgc_pkg::FUNC_CLEAR) begin
					seen = '0;
					n_clears++;
				end else begin
					verdict_q.insert(verdict_q.size(),
						predict_verdict(source_module, event_code));
					n_reports++;
				end
			end
		end
	end

	// Sender: hold a request until it is taken, then idle for a while or offer the next one
	always @(negedge clk) begin
		event_req_t nxt;
		if (in_valid && !req_taken) begin
			// hold the pending request unchanged
		end else if (tx_gap > 0) begin
			tx_gap--;
			in_valid <= 1'b0;
		end else if (pend_q.size() != 0) begin
			nxt = pend_q.pop_front();
			in_valid <= 1'b1;
			func <= nxt.fn;
			source_module <= nxt.mod;
			event_code <= nxt.evt;
			tx_gap = gap_len(tx_dense || tx_no_gap);
			if ($urandom_range(0, 63) == 0)
				tx_dense = !tx_dense;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver: random stalls, plus a long hold-off when the stimulus asks for one
	always @(negedge clk) begin
		if (rx_hold_len > 0) begin
			rx_hold_len--;
			out_ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			rx_gap = gap_len(rx_dense);
			if ($urandom_range(0, 63) == 0)
				rx_dense = !rx_dense;
		end
	end

	task automatic push_req(evgc_pkg::func_t fn, logic [evgc_pkg::ID_W-1:0] mod,
		logic [evgc_pkg::ID_W-1:0] evt);
		event_req_t r;
		r.fn = fn;
		r.mod = mod;
		r.evt = evt;
		pend_q.insert(pend_q.size(), r);
	endtask

	// Write one table entry; the caller makes sure the block is idle
	task automatic load_entry(int idx, evgc_pkg::entry_t val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= evgc_pkg::IDX_W'(idx);
		cfg_data <= val;
		tbl_img[idx] = val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Wait until every request is taken and every verdict is back, then let
	// a trailing clear request settle in the pipeline
	task automatic drain_all();
		do begin
			@(posedge clk);
			#1;
		end while (pend_q.size() != 0 || in_valid || verdict_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic evgc_pkg::entry_t mk_entry(logic en, evgc_pkg::class_t cls,
		logic [evgc_pkg::ID_W-1:0] mod, logic [evgc_pkg::ID_W-1:0] evt);
		evgc_pkg::entry_t e;
		e.enable = en;
		e.cls = cls;
		e.evt = evt;
		e.mod = mod;
		return e;
	endfunction

	// Random entry, mostly enabled, with ids often drawn from a tiny pool so that
	// several entries end up watching the same event
	function automatic evgc_pkg::entry_t rand_entry();
		evgc_pkg::entry_t e;
		e = evgc_pkg::entry_t'(evgc_pkg::CFG_W'($urandom));
		if ($urandom_range(0, 99) < 85)
			e.enable = 1'b1;
		if ($urandom_range(0, 99) < 40)
			e.mod = evgc_pkg::ID_W'($urandom_range(0, 3));
		if ($urandom_range(0, 99) < 40)
			e.evt = evgc_pkg::ID_W'($urandom_range(0, 3));
		return e;
	endfunction

	initial begin : stimulus
		int               pick;
		int               slot;
		evgc_pkg::entry_t img;
		evgc_pkg::entry_t val;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Empty table: every group is absent, so every report gives none
		push_req(evgc_pkg::FUNC_REPORT, 12'h000, 12'h000);
		push_req(evgc_pkg::FUNC_REPORT, 12'hfff, 12'hfff);
		push_req(evgc_pkg::FUNC_CLEAR, 12'hfff, 12'h000);
		push_req(evgc_pkg::FUNC_REPORT, 12'h000, 12'hfff);
		drain_all();

		// Directed table: id extremes, every class, a disabled entry on an event that
		// another entry watches, and two entries sharing one event
		load_entry(0, mk_entry(1'b1, evgc_pkg::CLS_OK_EVERY, 12'h000, 12'h000));
		load_entry(1, mk_entry(1'b1, evgc_pkg::CLS_OK_EVERY, 12'hfff, 12'hfff));
		load_entry(2, mk_entry(1'b1, evgc_pkg::CLS_OK_SOME, 12'h123, 12'h456));
		load_entry(3, mk_entry(1'b1, evgc_pkg::CLS_FAULT_SOME, 12'habc, 12'hdef));
		load_entry(4, mk_entry(1'b1, evgc_pkg::CLS_FAULT_EVERY, 12'h555, 12'haaa));
		load_entry(5, mk_entry(1'b1, evgc_pkg::CLS_FAULT_EVERY, 12'haaa, 12'h555));
		load_entry(6, mk_entry(1'b0, evgc_pkg::CLS_FAULT_SOME, 12'h000, 12'h000));
		load_entry(7, mk_entry(1'b1, evgc_pkg::CLS_OK_EVERY, 12'h123, 12'h456));
		// Climb through the ranking: all-valid, any-error, then all-error
		push_req(evgc_pkg::FUNC_REPORT, 12'h000, 12'h000);
		push_req(evgc_pkg::FUNC_REPORT, 12'hfff, 12'hfff);
		push_req(evgc_pkg::FUNC_REPORT, 12'h123, 12'h456);
		push_req(evgc_pkg::FUNC_REPORT, 12'habc, 12'hdef);
		push_req(evgc_pkg::FUNC_REPORT, 12'h555, 12'haaa);
		push_req(evgc_pkg::FUNC_REPORT, 12'haaa, 12'h555);
		// Clear, then an any-group alone, a half match and an empty result
		push_req(evgc_pkg::FUNC_CLEAR, 12'h000, 12'h000);
		push_req(evgc_pkg::FUNC_REPORT, 12'h123, 12'h456);
		push_req(evgc_pkg::FUNC_REPORT, 12'h000, 12'hfff);
		push_req(evgc_pkg::FUNC_CLEAR, 12'hfff, 12'hfff);
		push_req(evgc_pkg::FUNC_REPORT, 12'hfff, 12'h000);
		push_req(evgc_pkg::FUNC_REPORT, 12'habc, 12'hdef);
		drain_all();
		// Rewriting an entry drops its seen flag even with the same contents
		load_entry(3, tbl_img[3]);
		push_req(evgc_pkg::FUNC_REPORT, 12'h001, 12'h001);
		drain_all();

		// Random phases; the first three rewrite the whole table (random, all ones,
		// all zeros), later ones a random subset so older flags survive the rewrite
		for (int ph = 0; ph < 10; ph++) begin
			for (int i = 0; i < evgc_pkg::REG_SLOTS; i++) begin
				if (ph < 3 || $urandom_range(0, 1) == 1) begin
					case (ph)
						1: val = evgc_pkg::entry_t'({evgc_pkg::CFG_W{1'b1}});
						2: val = evgc_pkg::entry_t'({evgc_pkg::CFG_W{1'b0}});
						default: val = rand_entry();
					endcase
					load_entry(i, val);
				end
			end
			// One phase sends back to back while the receiver holds off, so the
			// pipeline fills and stalls the request channel
			tx_no_gap = (ph == 4);
			for (int n = 0; n < 200; n++) begin
				pick = $urandom_range(0, 99);
				slot = $urandom_range(0, evgc_pkg::REG_SLOTS - 1);
				img = tbl_img[slot];
				if (pick < 8)
					push_req(evgc_pkg::FUNC_CLEAR, evgc_pkg::ID_W'($urandom),
						evgc_pkg::ID_W'($urandom));
				else if (pick < 70)
					push_req(evgc_pkg::FUNC_REPORT, img.mod, img.evt);
				else if (pick < 80)
					push_req(evgc_pkg::FUNC_REPORT, img.mod, evgc_pkg::ID_W'($urandom));
				else
					push_req(evgc_pkg::FUNC_REPORT, evgc_pkg::ID_W'($urandom),
						evgc_pkg::ID_W'($urandom));
			end
			if (ph == 4)
				rx_hold_len = 150;
			drain_all();
			tx_no_gap = 1'b0;
		end

		$display("Sent %0d report and %0d clear requests; checked %0d verdicts.",
			n_reports, n_clears, n_checked);
		$display("Verdict mix: none %0d, error on all %0d, error on any %0d, %s %0d, %s %0d",
			verdict_hits[evgc_pkg::VERDICT_NONE], verdict_hits[evgc_pkg::VERDICT_FAULT_EVERY],
			verdict_hits[evgc_pkg::VERDICT_FAULT_SOME], "valid on all",
			verdict_hits[evgc_pkg::VERDICT_OK_EVERY], "valid on any",
			verdict_hits[evgc_pkg::VERDICT_OK_SOME]);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#10_000_000;
		$display("Run timed out with %0d verdicts outstanding", verdict_q.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
